// File: design/kwm_pkg.sv
package kwm_pkg;

  // Default number of head slots.
  localparam int MAX_LISTS_DEF = 8;

  // Fixed field widths.
  localparam int LIST_W  = 3;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 4;

  typedef logic signed [VALUE_W-1:0] elem_t;
  typedef logic [LIST_W-1:0]         list_idx_t;
  typedef logic [CFG_W-1:0]          count_t;

  // Reset value of the active list count.
  localparam count_t ACTIVE_RESET = count_t'(8);

  // Merge status seen after the current item has been applied.
  typedef struct packed {
    logic ready;
    logic any_full;
  } kwm_status_t;

  // Slot update command for the current item.
  typedef struct packed {
    logic pop;
    logic clear;
  } kwm_cmd_t;

endpackage

// File: design/k_way_sorted_merge_top.sv
// K-way sorted merge.
// The input channel (in_valid / in_stall) carries one item per transfer: the next
// element of list in_list_index, or its end marker when in_has_value is 0.
// The result channel (out_valid / out_stall) carries the smallest current head
// in out_value with its list in out_refill_list, or a done result with
// out_merge_done set once every active list has ended and no head is left.
// The list named in out_refill_list should send its next element or end marker.
// cfg_valid / cfg_ready writes the number of active lists; cfg_ready is always
// high and writes belong between merges.
// An item is registered on transfer and processed from the input register; any
// result it emits goes to the result register. One item per cycle is sustained
// unless the receiver stalls; slot update and comparator tree are combinational.
// When the receiver stalls with a result waiting, one more item is held in the
// input register and in_stall rises until the result leaves.
// Synchronous reset clears all head slots and end flags and sets the active
// list count to 8.
module k_way_sorted_merge_top import kwm_pkg::*; #(
  parameter int MAX_LISTS = MAX_LISTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  list_idx_t in_list_index,
  input  elem_t     in_elem_value,
  input  logic      in_has_value,
  output logic      out_valid,
  input  logic      out_stall,
  output elem_t     out_value,
  output list_idx_t out_refill_list,
  output logic      out_merge_done,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  count_t    cfg_active_lists
);

  localparam int IDX_W = $clog2(MAX_LISTS);

  count_t                active_lists_r;
  logic                  in_valid_r;
  logic                  in_valid_nxt;
  list_idx_t             in_idx_r;
  elem_t                 in_value_r;
  logic                  in_has_r;
  logic                  in_take;
  logic                  proc_en;
  logic                  emit;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  elem_t                 out_value_r;
  list_idx_t             out_refill_r;
  logic                  out_done_r;
  kwm_cmd_t              cmd;
  kwm_status_t           status;
  elem_t                 best_value;
  logic [IDX_W-1:0]      best_idx;
  logic [MAX_LISTS-1:0]  active_mask;
  logic [MAX_LISTS-1:0]  full_w;
  logic [MAX_LISTS-1:0]  ended_w;
  elem_t [MAX_LISTS-1:0] values_w;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_lists_r <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_lists_r <= cfg_active_lists;
    end
  end

  // The held item is processed unless a result is waiting on a stalled receiver.
  assign proc_en  = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !proc_en;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (proc_en) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_idx_r   <= in_list_index;
      in_value_r <= in_elem_value;
      in_has_r   <= in_has_value;
    end
  end

  kwm_slots #(
    .MAX_LISTS (MAX_LISTS),
    .IDX_W     (IDX_W)
  ) u_slots (
    .clk          (clk),
    .rst_n        (rst_n),
    .active_lists (active_lists_r),
    .wr_en        (proc_en),
    .wr_idx       (in_idx_r),
    .wr_value     (in_value_r),
    .wr_has       (in_has_r),
    .cmd          (cmd),
    .pop_idx      (best_idx),
    .active_mask  (active_mask),
    .full_w       (full_w),
    .ended_w      (ended_w),
    .values_w     (values_w)
  );

  kwm_select #(
    .MAX_LISTS (MAX_LISTS),
    .IDX_W     (IDX_W)
  ) u_select (
    .active_mask (active_mask),
    .full_w      (full_w),
    .ended_w     (ended_w),
    .values_w    (values_w),
    .status      (status),
    .best_value  (best_value),
    .best_idx    (best_idx)
  );

  // A processed item emits when the merge is ready: a head if any, else done.
  assign emit      = proc_en && status.ready;
  assign cmd.pop   = emit && status.any_full;
  assign cmd.clear = emit && !status.any_full;

  // Result register.
  assign out_valid_nxt = proc_en ? emit : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r  <= status.any_full ? best_value : '0;
      out_refill_r <= status.any_full ? LIST_W'(best_idx) : '0;
      out_done_r   <= !status.any_full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_refill_list = out_refill_r;
  assign out_merge_done  = out_done_r;

endmodule

// File: design/kwm_slots.sv
module kwm_slots import kwm_pkg::*; #(
  parameter int MAX_LISTS = MAX_LISTS_DEF,
  parameter int IDX_W     = $clog2(MAX_LISTS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  count_t                      active_lists,
  input  logic                        wr_en,
  input  list_idx_t                   wr_idx,
  input  elem_t                       wr_value,
  input  logic                        wr_has,
  input  kwm_cmd_t                    cmd,
  input  logic [IDX_W-1:0]            pop_idx,
  output logic [MAX_LISTS-1:0]        active_mask,
  output logic [MAX_LISTS-1:0]        full_w,
  output logic [MAX_LISTS-1:0]        ended_w,
  output elem_t [MAX_LISTS-1:0]       values_w
);

  elem_t                head_value_r [MAX_LISTS];
  logic [MAX_LISTS-1:0] head_full_r;
  logic [MAX_LISTS-1:0] head_full_nxt;
  logic [MAX_LISTS-1:0] list_ended_r;
  logic [MAX_LISTS-1:0] list_ended_nxt;
  logic [MAX_LISTS-1:0] hit;
  logic [MAX_LISTS-1:0] load;

  // Per-slot view after the incoming item is applied. A count of zero acts as one.
  for (genvar g = 0; g < MAX_LISTS; g++) begin : g_slot
    assign active_mask[g] = (g == 0) || (int'(active_lists) > g);
    assign hit[g]         = wr_en && active_mask[g] && (int'(wr_idx) == g) && !list_ended_r[g];
    assign load[g]        = hit[g] && wr_has && !head_full_r[g];
    assign full_w[g]      = head_full_r[g] || (hit[g] && wr_has);
    assign ended_w[g]     = list_ended_r[g] || (hit[g] && !wr_has);
    assign values_w[g]    = load[g] ? wr_value : head_value_r[g];
  end

  // Empty the emitted slot, or clear everything on the done result.
  always_comb begin
    head_full_nxt  = full_w;
    list_ended_nxt = ended_w;
    if (cmd.clear) begin
      head_full_nxt  = '0;
      list_ended_nxt = '0;
    end else if (cmd.pop) begin
      head_full_nxt[pop_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_full_r  <= '0;
      list_ended_r <= '0;
    end else begin
      head_full_r  <= head_full_nxt;
      list_ended_r <= list_ended_nxt;
    end
  end

  // Head values carry no reset; a head is only read while it is full.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LISTS; i++) begin
      if (load[i]) begin
        head_value_r[i] <= wr_value;
      end
    end
  end

endmodule

// File: design/kwm_select.sv
module kwm_select import kwm_pkg::*; #(
  parameter int MAX_LISTS = MAX_LISTS_DEF,
  parameter int IDX_W     = $clog2(MAX_LISTS)
) (
  input  logic [MAX_LISTS-1:0]  active_mask,
  input  logic [MAX_LISTS-1:0]  full_w,
  input  logic [MAX_LISTS-1:0]  ended_w,
  input  elem_t [MAX_LISTS-1:0] values_w,
  output kwm_status_t           status,
  output elem_t                 best_value,
  output logic [IDX_W-1:0]      best_idx
);

  localparam int LEAVES = 1 << $clog2(MAX_LISTS);
  localparam int NODES  = 2 * LEAVES - 1;

  logic             node_vld [NODES];
  elem_t            node_val [NODES];
  logic [IDX_W-1:0] node_idx [NODES];

  // Leaves hold the full active heads; padding leaves are empty.
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < MAX_LISTS) begin : g_real
      assign node_vld[LEAVES-1+g] = full_w[g] && active_mask[g];
      assign node_val[LEAVES-1+g] = values_w[g];
      assign node_idx[LEAVES-1+g] = IDX_W'(g);
    end else begin : g_pad
      assign node_vld[LEAVES-1+g] = 1'b0;
      assign node_val[LEAVES-1+g] = '0;
      assign node_idx[LEAVES-1+g] = '0;
    end
  end

  // Comparator tree. The left child covers lower indices, so a tie keeps the left.
  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    logic take_right;
    assign take_right  = node_vld[2*k+2] &&
                         (!node_vld[2*k+1] || (node_val[2*k+2] < node_val[2*k+1]));
    assign node_vld[k] = node_vld[2*k+1] || node_vld[2*k+2];
    assign node_val[k] = take_right ? node_val[2*k+2] : node_val[2*k+1];
    assign node_idx[k] = take_right ? node_idx[2*k+2] : node_idx[2*k+1];
  end

  // Ready when every active list has a head or has ended.
  assign status.ready    = &(~active_mask | full_w | ended_w);
  assign status.any_full = node_vld[0];
  assign best_value      = node_val[0];
  assign best_idx        = node_idx[0];

endmodule
